// ===== sv/ssr_pkg.sv =====
// shared types, codes and constants of the soft start ramp controller
// no dependencies; used by every module of the block
package ssr_pkg;

  // widths of the payload and the working registers
  localparam int unsigned DutyW  = 8;
  localparam int unsigned TicksW = 16;
  localparam int unsigned AccW   = 24;
  localparam int unsigned StepW  = 9;
  localparam int unsigned AluW   = 26;

  // reset value of the ramp length register and top duty
  localparam logic [TicksW-1:0] RAMP_TICKS_RESET = 16'd10000;
  localparam logic [DutyW-1:0]  DUTY_MAX         = 8'hFF;

  // default depth of the enable pin history ring
  localparam int unsigned HISTORY_DEPTH_DEF = 8;

  // ramp state as seen on the output
  typedef enum logic [1:0] {
    RS_DOWN      = 2'd0,
    RS_UP_RAMP   = 2'd1,
    RS_UP        = 2'd2,
    RS_DOWN_RAMP = 2'd3
  } ramp_state_e;

  // operation of the shared adder
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // debounced enable transitions of one tick
  typedef struct packed {
    logic rise;
    logic fall;
  } pin_edge_t;

endpackage

// ===== sv/ssr_alu.sv =====
// shared signed adder/subtractor used by the arithmetic steps of the sequencer
// depends on ssr_pkg
module ssr_alu (
  input  ssr_pkg::alu_op_e                     op_i,
  input  logic signed [ssr_pkg::AluW-1:0]      a_i,
  input  logic signed [ssr_pkg::AluW-1:0]      b_i,
  output logic signed [ssr_pkg::AluW-1:0]      res_o,
  output logic                                 neg_o,
  output logic                                 zero_o
);

  // single add or subtract with sign and zero flags
  always_comb begin
    unique case (op_i)
      ssr_pkg::ALU_ADD: res_o = a_i + b_i;
      ssr_pkg::ALU_SUB: res_o = a_i - b_i;
      default:          res_o = a_i + b_i;
    endcase
  end

  assign neg_o  = res_o[ssr_pkg::AluW-1];
  assign zero_o = (res_o == '0);

endmodule

// ===== sv/ssr_debounce.sv =====
// enable pin debouncer: ring of inverted samples, enable is the AND of all
// depends on ssr_pkg; reports the debounced edges of the last tick
module ssr_debounce #(
  parameter int unsigned Depth = ssr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_i,
  input  logic               pin_i,
  output ssr_pkg::pin_edge_t edge_o
);

  localparam int unsigned IdxW = $clog2(Depth);

  logic [Depth-1:0]   hist_q, hist_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               en_q, en_d;
  ssr_pkg::pin_edge_t edge_q, edge_d;

  // write the new sample into the ring and AND every entry
  always_comb begin
    hist_d = hist_q;
    idx_d  = idx_q;
    en_d   = en_q;
    edge_d = edge_q;
    if (sample_i) begin
      hist_d[idx_q] = ~pin_i;
      idx_d         = (idx_q == IdxW'(Depth - 1)) ? '0 : idx_q + 1'b1;
      en_d          = &hist_d;
      edge_d.rise   = ~en_q & en_d;
      edge_d.fall   = en_q & ~en_d;
    end
  end

  // ring, pointer, debounced level and edge flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      idx_q  <= '0;
      en_q   <= 1'b0;
      edge_q <= '0;
    end else begin
      hist_q <= hist_d;
      idx_q  <= idx_d;
      en_q   <= en_d;
      edge_q <= edge_d;
    end
  end

  assign edge_o = edge_q;

endmodule

// ===== sv/soft_start_ramp_controller.sv =====
// top level of the soft start ramp controller: sequencer and ramp registers
// depends on ssr_pkg, ssr_alu and ssr_debounce
//
//  channel   | direction | payload (low bit first)
//  s_axis    | in        | enable_pin[0], setpoint[8:1]
//  m_axis    | out       | duty[7:0], motor_enable[8], ramp_state_out[10:9]
//  cfg       | in        | ramp_ticks[15:0], written when cfg_we_i is high
//
// an input transfer runs through the sequencer steps around the one shared
// adder: a ramp step adds a clamp, a saturation check and, unless the duty saturates,
// 8 restoring divide steps; a ramp load adds 8 shift-add steps for each of the two products.
// s_axis_tready is high only while idle. the result sits in an output register, so
// the next input transfer is taken while it waits on m_axis_tready; a result that
// still waits then holds the sequencer in its output step. reset clears all control
// and ramp state.
module soft_start_ramp_controller #(
  parameter int unsigned HistoryDepth = ssr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // enable_pin [0], setpoint [8:1], zero [15:9]
  input  logic [15:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // duty [7:0], motor_enable [8], ramp_state_out [10:9], zero [15:11]
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned AluW = ssr_pkg::AluW;
  localparam int unsigned AccW = ssr_pkg::AccW;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RAMP  = 9'b000000010,
    S_CLAMP = 9'b000000100,
    S_DSAT  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_EDGE  = 9'b000100000,
    S_MULT  = 9'b001000000,
    S_MULD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } seq_state_e;

  seq_state_e                  seq_q, seq_d;
  ssr_pkg::ramp_state_e        rs_q, rs_d;
  logic [ssr_pkg::TicksW-1:0]  ticks_q;
  logic [ssr_pkg::DutyW-1:0]   duty_q, duty_d;
  logic [AccW-1:0]             acc_q, acc_d;
  logic [AccW-1:0]             tgt_acc_q, tgt_acc_d;
  logic [ssr_pkg::DutyW-1:0]   tgt_q, tgt_d;
  logic signed [ssr_pkg::StepW-1:0] step_q, step_d;
  logic [ssr_pkg::DutyW-1:0]   sp_q, sp_d;
  logic signed [AluW-1:0]      tmp_q, tmp_d;
  logic [15:0]                 rem_q, rem_d;
  logic [ssr_pkg::DutyW-1:0]   quot_q, quot_d;
  logic [2:0]                  cnt_q, cnt_d;
  logic [AccW-1:0]             mul_q, mul_d;
  logic                        load_up_q, load_up_d;
  logic                        ovld_q, ovld_d;
  logic [15:0]                 odata_q, odata_d;

  logic [ssr_pkg::TicksW-1:0]  t_eff;
  logic                        s_fire;
  ssr_pkg::pin_edge_t          pin_edge;
  ssr_pkg::alu_op_e            alu_op;
  logic signed [AluW-1:0]      alu_a, alu_b, alu_res;
  logic                        alu_neg, alu_zero;
  logic [16:0]                 trial;
  logic [ssr_pkg::DutyW-1:0]   mplr;
  logic                        clamp;

  assign t_eff  = (ticks_q == '0) ? ssr_pkg::TicksW'(1) : ticks_q;
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (seq_q == S_IDLE);

  // debounced enable edges, taken at each input transfer
  ssr_debounce #(
    .Depth (HistoryDepth)
  ) u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (s_fire),
    .pin_i    (s_axis_tdata_i[0]),
    .edge_o   (pin_edge)
  );

  // shared adder
  ssr_alu u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .neg_o  (alu_neg),
    .zero_o (alu_zero)
  );

  assign trial = {rem_q, acc_q[cnt_q]};
  assign mplr  = (seq_q == S_MULT) ? tgt_q : duty_q;

  // operand selection for the shared adder
  always_comb begin
    alu_op = ssr_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (seq_q)
      S_RAMP: begin
        alu_op = (rs_q == ssr_pkg::RS_DOWN_RAMP) ? ssr_pkg::ALU_SUB : ssr_pkg::ALU_ADD;
        alu_a  = AluW'(acc_q);
        alu_b  = AluW'(step_q);
      end
      S_CLAMP: begin
        alu_op = ssr_pkg::ALU_SUB;
        alu_a  = tmp_q;
        alu_b  = AluW'(tgt_acc_q);
      end
      S_DSAT: begin
        alu_op = ssr_pkg::ALU_SUB;
        alu_a  = AluW'(acc_q[AccW-1:8]);
        alu_b  = AluW'(t_eff);
      end
      S_DIV: begin
        alu_op = ssr_pkg::ALU_SUB;
        alu_a  = AluW'(trial);
        alu_b  = AluW'(t_eff);
      end
      S_EDGE: begin
        alu_op = ssr_pkg::ALU_SUB;
        alu_a  = pin_edge.rise ? AluW'(sp_q) : AluW'(duty_q);
        alu_b  = pin_edge.rise ? AluW'(duty_q) : '0;
      end
      S_MULT, S_MULD: begin
        alu_op = ssr_pkg::ALU_ADD;
        alu_a  = AluW'({mul_q[AccW-2:0], 1'b0});
        alu_b  = mplr[cnt_q] ? AluW'(t_eff) : '0;
      end
      S_IDLE, S_OUT: begin
        alu_op = ssr_pkg::ALU_ADD;
      end
      default: begin
        alu_op = ssr_pkg::ALU_ADD;
      end
    endcase
  end

  // clamp at the target in the direction of travel
  always_comb begin
    if (rs_q == ssr_pkg::RS_UP_RAMP && !step_q[ssr_pkg::StepW-1]) begin
      clamp = ~alu_neg & ~alu_zero;
    end else begin
      clamp = alu_neg;
    end
  end

  // sequencer
  always_comb begin
    seq_d     = seq_q;
    rs_d      = rs_q;
    duty_d    = duty_q;
    acc_d     = acc_q;
    tgt_acc_d = tgt_acc_q;
    tgt_d     = tgt_q;
    step_d    = step_q;
    sp_d      = sp_q;
    tmp_d     = tmp_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    cnt_d     = cnt_q;
    mul_d     = mul_q;
    load_up_d = load_up_q;
    ovld_d    = ovld_q;
    odata_d   = odata_q;

    // output register drains independently
    if (ovld_q && m_axis_tready_i) begin
      ovld_d = 1'b0;
    end

    unique case (seq_q)
      S_IDLE: begin
        if (s_fire) begin
          sp_d  = s_axis_tdata_i[8:1];
          seq_d = S_RAMP;
        end
      end
      // ramp step or state change
      S_RAMP: begin
        unique case (rs_q)
          ssr_pkg::RS_UP_RAMP: begin
            if (duty_q == tgt_q) begin
              rs_d   = ssr_pkg::RS_UP;
              duty_d = sp_q;
              seq_d  = S_EDGE;
            end else begin
              tmp_d = alu_res;
              seq_d = S_CLAMP;
            end
          end
          ssr_pkg::RS_DOWN_RAMP: begin
            if (duty_q == '0) begin
              rs_d  = ssr_pkg::RS_DOWN;
              seq_d = S_EDGE;
            end else begin
              tmp_d = alu_res;
              seq_d = S_CLAMP;
            end
          end
          ssr_pkg::RS_UP: begin
            duty_d = sp_q;
            seq_d  = S_EDGE;
          end
          ssr_pkg::RS_DOWN: begin
            seq_d = S_EDGE;
          end
          default: begin
            seq_d = S_EDGE;
          end
        endcase
      end
      S_CLAMP: begin
        acc_d = clamp ? tgt_acc_q : tmp_q[AccW-1:0];
        seq_d = S_DSAT;
      end
      // saturation check, then restoring divide by the ramp length
      S_DSAT: begin
        if (!alu_neg) begin
          duty_d = ssr_pkg::DUTY_MAX;
          seq_d  = S_EDGE;
        end else begin
          rem_d  = acc_q[AccW-1:8];
          quot_d = '0;
          cnt_d  = 3'd7;
          seq_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (!alu_neg) begin
          rem_d  = alu_res[15:0];
          quot_d = {quot_q[6:0], 1'b1};
        end else begin
          rem_d  = trial[15:0];
          quot_d = {quot_q[6:0], 1'b0};
        end
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == '0) begin
          duty_d = {quot_q[6:0], ~alu_neg};
          seq_d  = S_EDGE;
        end
      end
      // debounced edge loads a new ramp
      S_EDGE: begin
        if (pin_edge.rise &&
            (rs_q == ssr_pkg::RS_DOWN || rs_q == ssr_pkg::RS_DOWN_RAMP)) begin
          load_up_d = 1'b1;
          tgt_d     = sp_q;
          step_d    = alu_res[ssr_pkg::StepW-1:0];
          mul_d     = '0;
          cnt_d     = 3'd7;
          seq_d     = S_MULT;
        end else if (pin_edge.fall &&
            (rs_q == ssr_pkg::RS_UP_RAMP || rs_q == ssr_pkg::RS_UP)) begin
          load_up_d = 1'b0;
          tgt_d     = '0;
          step_d    = alu_res[ssr_pkg::StepW-1:0];
          mul_d     = '0;
          cnt_d     = 3'd7;
          seq_d     = S_MULT;
        end else begin
          seq_d = S_OUT;
        end
      end
      // shift-add products: ramp length times target, then times duty
      S_MULT: begin
        mul_d = alu_res[AccW-1:0];
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == '0) begin
          tgt_acc_d = alu_res[AccW-1:0];
          mul_d     = '0;
          cnt_d     = 3'd7;
          seq_d     = S_MULD;
        end
      end
      S_MULD: begin
        mul_d = alu_res[AccW-1:0];
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == '0) begin
          acc_d = alu_res[AccW-1:0];
          rs_d  = load_up_q ? ssr_pkg::RS_UP_RAMP : ssr_pkg::RS_DOWN_RAMP;
          seq_d = S_OUT;
        end
      end
      // hand the result to the output register
      S_OUT: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d  = 1'b1;
          odata_d = {5'b0, rs_q, (rs_q != ssr_pkg::RS_DOWN), duty_q};
          seq_d   = S_IDLE;
        end
      end
      default: begin
        seq_d = S_IDLE;
      end
    endcase
  end

  // control and ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= S_IDLE;
      rs_q      <= ssr_pkg::RS_DOWN;
      ticks_q   <= ssr_pkg::RAMP_TICKS_RESET;
      duty_q    <= '0;
      acc_q     <= '0;
      tgt_acc_q <= '0;
      tgt_q     <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
      load_up_q <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      rs_q      <= rs_d;
      duty_q    <= duty_d;
      acc_q     <= acc_d;
      tgt_acc_q <= tgt_acc_d;
      tgt_q     <= tgt_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      load_up_q <= load_up_d;
      ovld_q    <= ovld_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    sp_q    <= sp_d;
    tmp_q   <= tmp_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    mul_q   <= mul_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

// ===== verif/soft_start_ramp_controller_tb.sv =====
// self-checking testbench for soft_start_ramp_controller: directed table, then random
// enable/setpoint episodes checked against a built-in ramp predictor
// depends on ssr_pkg and the soft_start_ramp_controller rtl
module soft_start_ramp_controller_tb;

  localparam int unsigned HistDepth  = ssr_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned PhaseTicks = 55;
  localparam int unsigned NumPhases  = 10;

  // one drive output as the block reports it
  typedef struct packed {
    logic [7:0]           duty;
    logic                 en;
    ssr_pkg::ramp_state_e st;
  } drive_t;

  // one row of the directed table: a register write or a tick
  typedef struct packed {
    bit          is_cfg;
    logic [15:0] cfg_val;
    logic        pin;
    logic [7:0]  sp;
    bit          fixed;
    drive_t      want;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic [15:0] s_data = '0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  soft_start_ramp_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // shadow copy of the controller state
  logic [15:0]          shadow_ticks      = ssr_pkg::RAMP_TICKS_RESET;
  ssr_pkg::ramp_state_e shadow_state      = ssr_pkg::RS_DOWN;
  logic [7:0]           shadow_duty       = '0;
  logic [23:0]          shadow_acc        = '0;
  logic [23:0]          shadow_acc_target = '0;
  logic [7:0]           shadow_target     = '0;
  int                   shadow_step       = 0;
  logic [HistDepth-1:0] shadow_pins       = '0;
  int unsigned          shadow_pin_pos    = 0;
  logic                 shadow_enabled    = 1'b0;

  drive_t      pending_drive_q[$];
  int unsigned fail_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned outputs_checked = 0;
  int unsigned ticks_settings = 0;
  int unsigned state_hits[4] = '{0, 0, 0, 0};
  bit          no_idle = 1'b0;
  bit          hold_request = 1'b0;

  // directed table: reset state, debounce, both ramps at the slow default and at zero ticks
  step_row_t dir_rows [27] = '{
    '{1'b0, 16'd0, 1'b1, 8'hFF, 1'b1, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    // eighth enabled sample in a row: debounced rise
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b1, '{8'h00, 1'b1, ssr_pkg::RS_UP_RAMP}},
    '{1'b0, 16'd0, 1'b0, 8'h80, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b1, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    // zero ramp length acts as one tick
    '{1'b1, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b1, '{8'h00, 1'b1, ssr_pkg::RS_UP_RAMP}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b1, '{8'hFF, 1'b1, ssr_pkg::RS_UP_RAMP}},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b1, '{8'h00, 1'b1, ssr_pkg::RS_UP}},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b1, '{8'hFF, 1'b1, ssr_pkg::RS_UP}},
    '{1'b0, 16'd0, 1'b1, 8'hFF, 1'b1, '{8'hFF, 1'b1, ssr_pkg::RS_DOWN_RAMP}},
    '{1'b0, 16'd0, 1'b1, 8'h00, 1'b1, '{8'h00, 1'b1, ssr_pkg::RS_DOWN_RAMP}},
    '{1'b0, 16'd0, 1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, ssr_pkg::RS_DOWN}}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // divisor of the accumulator, zero ticks count as one
  function automatic int unsigned ramp_divisor();
    return (shadow_ticks == 16'd0) ? 1 : int'(shadow_ticks);
  endfunction

  function automatic logic [7:0] duty_of_acc(input logic [23:0] acc);
    int unsigned q;
    q = acc / ramp_divisor();
    return (q > ssr_pkg::DUTY_MAX) ? ssr_pkg::DUTY_MAX : q[7:0];
  endfunction

  // latch a new ramp from the present duty toward goal
  function automatic void load_ramp(input logic [7:0] goal,
                                    input ssr_pkg::ramp_state_e next);
    longint unsigned t;
    t = ramp_divisor();
    shadow_target     = goal;
    shadow_acc_target = 24'(t * goal);
    shadow_acc        = 24'(t * shadow_duty);
    shadow_step       = int'(goal) - int'(shadow_duty);
    if (next == ssr_pkg::RS_DOWN_RAMP) shadow_step = -shadow_step;
    shadow_state = next;
  endfunction

  // one tick: ramp first, then debounce and edge handling
  function automatic drive_t predict_drive(input logic pin, input logic [7:0] sp);
    longint a;
    logic   was_enabled;
    drive_t r;
    if (shadow_state == ssr_pkg::RS_UP_RAMP) begin
      if (shadow_duty == shadow_target) begin
        shadow_state = ssr_pkg::RS_UP;
      end else begin
        a = longint'(shadow_acc) + shadow_step;
        if (shadow_step >= 0) begin
          if (a > longint'(shadow_acc_target)) a = shadow_acc_target;
        end else begin
          if (a < longint'(shadow_acc_target)) a = shadow_acc_target;
        end
        if (a < 0) a = 0;
        shadow_acc  = a[23:0];
        shadow_duty = duty_of_acc(shadow_acc);
      end
    end
    if (shadow_state == ssr_pkg::RS_DOWN_RAMP) begin
      if (shadow_duty == 8'd0) begin
        shadow_state = ssr_pkg::RS_DOWN;
      end else begin
        a = longint'(shadow_acc) - shadow_step;
        if (a < longint'(shadow_acc_target)) a = shadow_acc_target;
        if (a < 0) a = 0;
        shadow_acc  = a[23:0];
        shadow_duty = duty_of_acc(shadow_acc);
      end
    end
    if (shadow_state == ssr_pkg::RS_UP) shadow_duty = sp;

    // debounce: every sample in the ring must be enabled
    was_enabled = shadow_enabled;
    shadow_pins[shadow_pin_pos] = ~pin;
    shadow_pin_pos = (shadow_pin_pos + 1) % HistDepth;
    shadow_enabled = &shadow_pins;

    if (!was_enabled && shadow_enabled) begin
      if (shadow_state == ssr_pkg::RS_DOWN || shadow_state == ssr_pkg::RS_DOWN_RAMP)
        load_ramp(sp, ssr_pkg::RS_UP_RAMP);
    end else if (was_enabled && !shadow_enabled) begin
      if (shadow_state == ssr_pkg::RS_UP_RAMP || shadow_state == ssr_pkg::RS_UP)
        load_ramp(8'd0, ssr_pkg::RS_DOWN_RAMP);
    end

    r.duty = shadow_duty;
    r.en   = (shadow_state != ssr_pkg::RS_DOWN);
    r.st   = shadow_state;
    return r;
  endfunction

  // setpoint with the two extremes weighted up
  function automatic logic [7:0] pick_setpoint();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // offer one tick, wait for the transfer, record what must come back
  task automatic send_tick(input logic pin, input logic [7:0] sp, input bit fixed,
                           input drive_t typed);
    drive_t want;
    if (!no_idle) begin
      while ($urandom_range(99) < 35) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, sp, pin};
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = predict_drive(pin, sp);
    pending_drive_q.push_back(fixed ? typed : want);
    ticks_sent++;
  endtask

  // stop offering and wait until every drive output has come back
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_drive_q.size() != 0);
  endtask

  task automatic set_ramp_ticks(input logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    shadow_ticks = value;
    cfg_we <= 1'b0;
    ticks_settings++;
  endtask

  // result side: random backpressure, long hold on request, checking
  initial begin : drive_sink
    int unsigned hold_left;
    drive_t      got;
    drive_t      want;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) begin
        got.duty = m_axis_tdata_o[7:0];
        got.en   = m_axis_tdata_o[8];
        got.st   = ssr_pkg::ramp_state_e'(m_axis_tdata_o[10:9]);
        state_hits[got.st]++;
        if (pending_drive_q.size() == 0) begin
          $error("drive output transfer with none expected: tdata %h", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = pending_drive_q.pop_front();
          outputs_checked++;
          if (got.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, got.duty);
            fail_count++;
          end
          if (got.en !== want.en) begin
            $error("motor_enable: expected %0d, actual %0d", want.en, got.en);
            fail_count++;
          end
          if (got.st !== want.st) begin
            $error("ramp_state_out: expected %0d, actual %0d", want.st, got.st);
            fail_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= no_idle || ($urandom_range(99) >= 35);
      end
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  initial begin : quiet_watch
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", QuietLimit);
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [8:0]  plan_q[$];
    logic [8:0]  item;
    logic [7:0]  run_sp;
    logic [15:0] ticks_val;
    int unsigned kind;
    bit          vary;
    drive_t      none;

    none = '{8'h00, 1'b0, ssr_pkg::RS_DOWN};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_ramp_ticks(dir_rows[i].cfg_val);
      else send_tick(dir_rows[i].pin, dir_rows[i].sp, dir_rows[i].fixed, dir_rows[i].want);
    end

    // random phases, each with its own ramp length
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       ticks_val = 16'd1;
        1:       ticks_val = 16'd3;
        2:       ticks_val = 16'hFFFF;
        default: begin
          kind = $urandom_range(99);
          if (kind < 15)      ticks_val = 16'($urandom_range(65535));
          else if (kind < 25) ticks_val = 16'd0;
          else                ticks_val = 16'($urandom_range(1, 40));
        end
      endcase
      set_ramp_ticks(ticks_val);
      no_idle = (ph == 4);
      if (ph == 6) hold_request = 1'b1;

      // mostly clean enable runs, some short broken runs and pin noise
      plan_q.delete();
      while (plan_q.size() < PhaseTicks) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          run_sp = pick_setpoint();
          vary   = $urandom_range(1);
          repeat ($urandom_range(8, 60)) plan_q.push_back({vary ? pick_setpoint() : run_sp, 1'b0});
          repeat ($urandom_range(1, 30)) plan_q.push_back({pick_setpoint(), 1'b1});
        end else if (kind < 85) begin
          repeat ($urandom_range(1, 7)) plan_q.push_back({pick_setpoint(), 1'b0});
          repeat ($urandom_range(1, 4)) plan_q.push_back({pick_setpoint(), 1'b1});
        end else begin
          repeat ($urandom_range(4, 16)) plan_q.push_back({pick_setpoint(), 1'($urandom_range(1))});
        end
      end

      foreach (plan_q[k]) begin
        if (ph == 2 && k == plan_q.size() / 2) drain_results();
        item = plan_q[k];
        send_tick(item[0], item[8:1], 1'b0, none);
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (DrainWait) @(posedge clk_i);
    $display("%0d ticks sent, %0d drive outputs checked, %0d ramp length settings",
             ticks_sent, outputs_checked, ticks_settings);
    $display("states seen: down %0d, ramping up %0d, up %0d, ramping down %0d",
             state_hits[0], state_hits[1], state_hits[2], state_hits[3]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
